// ===== hw/rtl/mcadcma_pkg.sv =====
// ----------------------------------------------------------------------------
// mcadcma_pkg
// Shared types and constants for the multichannel converter moving average.
// ----------------------------------------------------------------------------
`default_nettype none

package mcadcma_pkg;

  localparam int unsigned CHANNELS       = 5;
  localparam int unsigned SAMPLE_W       = 12;
  localparam int unsigned WINDOW_DEFAULT = 8;

  // Channel positions within one scan
  localparam int unsigned CH_BATT = 0;
  localparam int unsigned CH_VOUT = 1;
  localparam int unsigned CH_IOUT = 2;
  localparam int unsigned CH_VIN  = 3;
  localparam int unsigned CH_TEMP = 4;

  typedef logic [SAMPLE_W-1:0]   sample_t;
  typedef sample_t [CHANNELS-1:0] scan_t;

endpackage

`default_nettype wire

// ===== hw/rtl/mcadcma_window_ram.sv =====
// ----------------------------------------------------------------------------
// mcadcma_window_ram
// Ring window storage: one scan per entry, registered read, one write port.
// Entries never written since reset read as zero.
// ----------------------------------------------------------------------------
`default_nettype none

module mcadcma_window_ram
  import mcadcma_pkg::*;
#(
  parameter int unsigned WINDOW = WINDOW_DEFAULT,
  localparam int unsigned SLOT_W = $clog2(WINDOW)
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              rd_en_i,
  input  wire logic [SLOT_W-1:0] rd_addr_i,
  output scan_t                  rd_data_o,
  input  wire logic              wr_en_i,
  input  wire logic [SLOT_W-1:0] wr_addr_i,
  input  wire scan_t             wr_data_i
);

  scan_t             mem_q [WINDOW];
  scan_t             rd_data_q;
  logic [WINDOW-1:0] valid_q;
  logic              rd_valid_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (rd_en_i) begin
        rd_valid_q <= valid_q[rd_addr_i];
      end
      if (wr_en_i) begin
        valid_q[wr_addr_i] <= 1'b1;
      end
    end
  end

  assign rd_data_o = rd_valid_q ? rd_data_q : '0;

endmodule

`default_nettype wire

// ===== hw/rtl/multichannel_adc_moving_average.sv =====
// ----------------------------------------------------------------------------
// multichannel_adc_moving_average
// Order: an accepted scan passes stages 1, 2 and 3 into the output register.
// Throughput: one scan per cycle unless the output is held. A scan reads one
//   window RAM slot, rewrites it on stage 1 exit and updates each channel sum.
// Reset: windows read as zero, sums, ring slot and offset clear at once;
//   no clearing pass, the block takes a scan in the first cycle after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module multichannel_adc_moving_average
  import mcadcma_pkg::*;
#(
  parameter int unsigned WINDOW = WINDOW_DEFAULT
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  // configuration: current offset
  input  wire logic                cfg_we_i,
  input  wire logic [SAMPLE_W-1:0] cfg_wdata_i,
  // scan input
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire logic [SAMPLE_W-1:0] batt_sample_i,
  input  wire logic [SAMPLE_W-1:0] vout_sample_i,
  input  wire logic [SAMPLE_W-1:0] iout_sample_i,
  input  wire logic [SAMPLE_W-1:0] vin_sample_i,
  input  wire logic [SAMPLE_W-1:0] temp_sample_i,
  // averages output
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output logic [SAMPLE_W-1:0]      batt_avg_o,
  output logic [SAMPLE_W-1:0]      vout_avg_o,
  output logic [SAMPLE_W-1:0]      iout_avg_o,
  output logic [SAMPLE_W-1:0]      vin_avg_o,
  output logic [SAMPLE_W-1:0]      temp_avg_o
);

  // Window sum of one channel needs log2(WINDOW) extra bits.
  localparam int unsigned SLOT_W = $clog2(WINDOW);
  localparam int unsigned SUM_W  = SAMPLE_W + SLOT_W;
  // Exact divide by WINDOW through a reciprocal: for any sum below 2**SUM_W,
  // floor(sum * RECIP / 2**SHIFT) equals floor(sum / WINDOW) when
  // RECIP = ceil(2**SHIFT / WINDOW) and SHIFT = SUM_W + ceil(log2 WINDOW).
  localparam int unsigned SHIFT     = SUM_W + SLOT_W;
  localparam int unsigned RECIP_INT = ((32'd1 << SHIFT) + WINDOW - 1) / WINDOW;
  localparam int unsigned PROD_W    = 2 * SUM_W + 1;
  localparam logic [SUM_W:0]   RECIP   = (SUM_W + 1)'(RECIP_INT);
  localparam logic [SUM_W-1:0] SUM_MAX = SUM_W'(((1 << SAMPLE_W) - 1) * WINDOW);
  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(WINDOW - 1);

  // --------------------------------------------------------------------------
  // Pipeline handshake
  //   stage 1: RAM read of the slot about to be overwritten is in flight
  //   stage 2: running sums hold this scan's window totals; multiply
  //   stage 3: quotients; apply current offset into the output register
  // Each stage advances when the next one is empty or advancing itself.
  // --------------------------------------------------------------------------
  logic s1_valid_q, s2_valid_q, s3_valid_q, out_valid_q;
  logic s1_adv, s2_adv, s3_adv, in_accept;

  assign s3_adv     = s3_valid_q && (!out_valid_q || out_ready_i);
  assign s2_adv     = s2_valid_q && (!s3_valid_q || s3_adv);
  assign s1_adv     = s1_valid_q && (!s2_valid_q || s2_adv);
  assign in_ready_o = !s1_valid_q || s1_adv;
  assign in_accept  = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      s3_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_accept) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_adv) begin
        s2_valid_q <= 1'b1;
      end else if (s2_adv) begin
        s2_valid_q <= 1'b0;
      end
      if (s2_adv) begin
        s3_valid_q <= 1'b1;
      end else if (s3_adv) begin
        s3_valid_q <= 1'b0;
      end
      if (s3_adv) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;

  // --------------------------------------------------------------------------
  // Configuration
  // --------------------------------------------------------------------------
  logic [SAMPLE_W-1:0] offset_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q <= '0;
    end else if (cfg_we_i) begin
      offset_q <= cfg_wdata_i;
    end
  end

  // --------------------------------------------------------------------------
  // Ring slot and stage 1 capture
  // --------------------------------------------------------------------------
  scan_t             in_scan;
  scan_t             s1_scan_q;
  logic [SLOT_W-1:0] slot_q, slot_d, s1_slot_q;

  always_comb begin
    in_scan          = '0;
    in_scan[CH_BATT] = batt_sample_i;
    in_scan[CH_VOUT] = vout_sample_i;
    in_scan[CH_IOUT] = iout_sample_i;
    in_scan[CH_VIN]  = vin_sample_i;
    in_scan[CH_TEMP] = temp_sample_i;
  end

  assign slot_d = (slot_q == SLOT_LAST) ? '0 : slot_q + 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q <= '0;
    end else if (in_accept) begin
      slot_q <= slot_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_scan_q <= in_scan;
      s1_slot_q <= slot_q;
    end
  end

  // --------------------------------------------------------------------------
  // Window RAM: read the oldest scan on accept, overwrite it on stage 1 exit.
  // At most one scan sits in stage 1 and its write leaves the stage in the
  // same cycle the next read enters, always on a different slot since the
  // window is at least two deep, so no forwarding is needed.
  // --------------------------------------------------------------------------
  scan_t old_scan;

  mcadcma_window_ram #(
    .WINDOW (WINDOW)
  ) u_window_ram (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (in_accept),
    .rd_addr_i (slot_q),
    .rd_data_o (old_scan),
    .wr_en_i   (s1_adv),
    .wr_addr_i (s1_slot_q),
    .wr_data_i (s1_scan_q)
  );

  // --------------------------------------------------------------------------
  // Running sums: add the new sample, drop the one it replaces.
  // sum_q only moves on stage 1 exit, which needs stage 2 free, so while
  // stage 2 holds a scan, sum_q still carries that scan's totals.
  // --------------------------------------------------------------------------
  logic [SUM_W-1:0] sum_q [CHANNELS];
  logic [SUM_W-1:0] sum_d [CHANNELS];

  always_comb begin
    for (int ch = 0; ch < CHANNELS; ch++) begin
      sum_d[ch] = sum_q[ch] + SUM_W'(s1_scan_q[ch]) - SUM_W'(old_scan[ch]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int ch = 0; ch < CHANNELS; ch++) begin
        sum_q[ch] <= '0;
      end
    end else if (s1_adv) begin
      for (int ch = 0; ch < CHANNELS; ch++) begin
        sum_q[ch] <= sum_d[ch];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: divide by WINDOW through the reciprocal multiply
  // --------------------------------------------------------------------------
  logic [PROD_W-1:0] prod [CHANNELS];
  scan_t             quot_d;
  scan_t             s3_quot_q;

  always_comb begin
    for (int ch = 0; ch < CHANNELS; ch++) begin
      prod[ch]   = PROD_W'(sum_q[ch]) * PROD_W'(RECIP);
      quot_d[ch] = prod[ch][SHIFT +: SAMPLE_W];
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_adv) begin
      s3_quot_q <= quot_d;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: subtract the zero-current code from iout only, clamp at zero
  // --------------------------------------------------------------------------
  scan_t avg_d, avg_q;

  always_comb begin
    avg_d = s3_quot_q;
    if (s3_quot_q[CH_IOUT] > offset_q) begin
      avg_d[CH_IOUT] = s3_quot_q[CH_IOUT] - offset_q;
    end else begin
      avg_d[CH_IOUT] = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s3_adv) begin
      avg_q <= avg_d;
    end
  end

  assign batt_avg_o = avg_q[CH_BATT];
  assign vout_avg_o = avg_q[CH_VOUT];
  assign iout_avg_o = avg_q[CH_IOUT];
  assign vin_avg_o  = avg_q[CH_VIN];
  assign temp_avg_o = avg_q[CH_TEMP];

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  // Input only stalls when every stage is full and the output is held.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (s1_valid_q && s2_valid_q && s3_valid_q && out_valid_q && !out_ready_i))
    else $error("input stalled while the pipeline has room");

  // A read and a write-back in the same cycle never touch the same slot.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && s1_adv) |-> (slot_q != s1_slot_q))
    else $error("window RAM read and write collide on one slot");

  // Ring slot advances by one per accepted beat and wraps after the window.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> (slot_q == (($past(slot_q) == SLOT_LAST) ? '0 : $past(slot_q) + 1'b1)))
    else $error("ring slot did not advance correctly");

  // A running sum never exceeds a full window of maximum codes.
  for (genvar gc = 0; gc < CHANNELS; gc++) begin : g_sum_chk
    assert property (@(posedge clk_i) disable iff (!rst_ni)
      sum_q[gc] <= SUM_MAX)
      else $error("running sum out of range");
  end

endmodule

`default_nettype wire
